// ----- hw/rtl/rmv_pkg.sv -----
package rmv_pkg;

    // Fixed field widths of the stream payload
    localparam int SAMPLE_W    = 32;
    localparam int MEAN_W      = 32;
    localparam int MAG_W       = 32;
    localparam int COUNT_OUT_W = 32;
    localparam int M2_W        = 63;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int OUT_DATA_W  = 256;

    localparam logic [M2_W-1:0] M2_MAX = '1;

    // Handshake status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } rmv_unit_status_t;

endpackage

// ----- hw/rtl/running_mean_variance.sv -----
// Running mean and variance of a stream of signed fixed-point samples, updated
// by the Welford recurrence. Each accepted sample raises a saturating count,
// moves the mean by delta/count (truncated toward zero) and adds the rounded-
// down product of the two deviations to a saturating sum of squares; one
// result transaction follows per sample, carrying count, mean, that sum and
// the population and sample variances. One sample is in work at a time: the
// work runs three divisions on one shared restoring divider that yields one
// quotient bit per cycle, a bit-serial 32x32 multiplier, and a nine-state
// sequencer around them. A new sample is taken while the previous result
// still waits in the output register.
module running_mean_variance
    import rmv_pkg::*;
#(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] sample_count, [63:32] running_mean,
                                             // [126:64] sum_sq_dev, [189:127] pop_variance,
                                             // [252:190] samp_variance, [255:253] zero
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MDIV = 9'b000000010,
        S_D2   = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_ACC  = 9'b000010000,
        S_PST  = 9'b000100000,
        S_PDIV = 9'b001000000,
        S_SDIV = 9'b010000000,
        S_DONE = 9'b100000000
    } rmv_state_t;

    rmv_state_t              state_reg, state_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [MEAN_W-1:0]       mean_reg, mean_next;
    logic [M2_W-1:0]         m2_reg, m2_next;
    logic [SAMPLE_W-1:0]     x_reg, x_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [M2_W-1:0]         pvar_reg, pvar_next;
    logic [M2_W-1:0]         svar_reg, svar_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;

    logic                    accept;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic [COUNT_WIDTH-1:0]  sdiv;
    logic [MAG_W:0]          delta;
    logic [MAG_W:0]          delta_neg;
    logic [MAG_W:0]          q_step;
    logic [MAG_W:0]          mean_sum;
    logic [MAG_W:0]          delta2;
    logic [MAG_W:0]          delta2_neg;
    logic [MAG_W-1:0]        mag2;
    logic [PROD_W-1:0]       prod_shift;
    logic [M2_W-1:0]         add_sat;
    logic [M2_W:0]           m2_sum;
    logic [63:0]             count_ext;

    logic                    div_start;
    logic [M2_W-1:0]         div_dividend;
    logic [COUNT_WIDTH-1:0]  div_divisor;
    logic [M2_W-1:0]         div_quotient;
    rmv_unit_status_t        div_st;

    logic                    mul_start;
    logic [PROD_W-1:0]       mul_product;
    rmv_unit_status_t        mul_st;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Saturating count and the divisor for the sample variance
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);
    assign sdiv      = (count_reg > COUNT_WIDTH'(2)) ? count_reg - COUNT_WIDTH'(1)
                                                     : COUNT_WIDTH'(1);

    // First deviation against the old mean
    assign delta     = {s_tdata[SAMPLE_W-1], s_tdata} - {mean_reg[MEAN_W-1], mean_reg};
    assign delta_neg = -delta;

    // Mean step with the sign of the first deviation
    assign q_step   = neg_reg ? -div_quotient[MAG_W:0] : div_quotient[MAG_W:0];
    assign mean_sum = {mean_reg[MEAN_W-1], mean_reg} + q_step;

    // Second deviation against the new mean
    assign delta2     = {x_reg[SAMPLE_W-1], x_reg} - {mean_reg[MEAN_W-1], mean_reg};
    assign delta2_neg = -delta2;
    assign mag2       = delta2[MAG_W] ? delta2_neg[MAG_W-1:0] : delta2[MAG_W-1:0];

    // Scale the product and add it to the sum of squares, clamping both
    assign prod_shift = mul_product >> FRAC_BITS;
    assign add_sat    = prod_shift[PROD_W-1] ? M2_MAX : prod_shift[M2_W-1:0];
    assign m2_sum     = {1'b0, m2_reg} + {1'b0, add_sat};

    assign count_ext = 64'(count_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mean_next      = mean_reg;
        m2_next        = m2_reg;
        x_next         = x_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        pvar_next      = pvar_reg;
        svar_next      = svar_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_dividend   = m2_reg;
        div_divisor    = count_reg;
        mul_start      = 1'b0;

        // Release the result once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_next       = s_tdata;
                    count_next   = count_inc;
                    neg_next     = delta[MAG_W];
                    mag_next     = delta[MAG_W] ? delta_neg[MAG_W-1:0] : delta[MAG_W-1:0];
                    div_start    = 1'b1;
                    div_dividend = M2_W'(mag_next);
                    div_divisor  = count_inc;
                    state_next   = S_MDIV;
                end
            end
            S_MDIV:
            begin
                if (div_st.done)
                begin
                    mean_next  = mean_sum[MEAN_W-1:0];
                    state_next = S_D2;
                end
            end
            S_D2:
            begin
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_st.done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                m2_next    = m2_sum[M2_W] ? M2_MAX : m2_sum[M2_W-1:0];
                state_next = S_PST;
            end
            S_PST:
            begin
                div_start  = 1'b1;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                if (div_st.done)
                begin
                    pvar_next   = div_quotient;
                    div_start   = 1'b1;
                    div_divisor = sdiv;
                    state_next  = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_st.done)
                begin
                    svar_next  = div_quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, svar_reg, pvar_reg, m2_reg, mean_reg,
                                      count_ext[COUNT_OUT_W-1:0]};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and model state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mean_reg      <= mean_next;
            m2_reg        <= m2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        pvar_reg     <= pvar_next;
        svar_reg     <= svar_next;
        out_data_reg <= out_data_next;
    end

    // Shared divider for the mean step and both variances
    rmv_div #(
        .DIVIDEND_W (M2_W),
        .DIVISOR_W  (COUNT_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_st)
    );

    // Product of the two deviation magnitudes
    rmv_mul #(
        .OP_W (MAG_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mag_reg),
        .op_b    (mag2),
        .product (mul_product),
        .status  (mul_st)
    );

    // A sample is only taken while the divider is free
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !div_st.busy)
        else $error("sample accepted while divider busy");

    // Divider results arrive only in states that consume them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_MDIV || state_reg == S_PDIV || state_reg == S_SDIV))
        else $error("divider result arrived in an unexpected state");

    // The sum of squares never falls
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |=> (m2_reg >= $past(m2_reg)))
        else $error("sum of squared deviations decreased");

    // The count never falls and moves by at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + COUNT_WIDTH'(1)))
        else $error("count moved by other than one");

endmodule

// ----- hw/rtl/rmv_div.sv -----
module rmv_div
    import rmv_pkg::*;
#(
    parameter int DIVIDEND_W = 63,
    parameter int DIVISOR_W  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output rmv_unit_status_t      status
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // Trial subtraction of one restoring step
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    // Load on start, then retire one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ----- hw/rtl/rmv_mul.sv -----
module rmv_mul
    import rmv_pkg::*;
#(
    parameter int OP_W = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [OP_W-1:0]     op_a,
    input  logic [OP_W-1:0]     op_b,
    output logic [2*OP_W-1:0]   product,
    output rmv_unit_status_t    status
);

    localparam int CNT_W = $clog2(OP_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [OP_W-1:0]     a_reg, a_next;
    logic [2*OP_W-1:0]   p_reg, p_next;

    logic [OP_W:0]       sum;

    // Add the multiplicand when the current multiplier bit is set
    assign sum = {1'b0, p_reg[2*OP_W-1:OP_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    // Load on start, then consume one multiplier bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        p_next    = p_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OP_W - 1);
            a_next    = op_a;
            p_next    = {{OP_W{1'b0}}, op_b};
        end
        else if (busy_reg)
        begin
            p_next = {sum, p_reg[OP_W-1:1]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        p_reg   <= p_next;
    end

    assign product     = p_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
